/* design/rcfd_pkg.sv */
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the remote-control frame decoder: register
// indexes, reset values, the queued frame snapshot and the decoded result.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int WIN_LEN = 18;

    // Input beat kinds carried on s_tuser.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // Configuration register indexes.
    localparam logic [3:0] REG_IDLE_LIMIT  = 4'd0;
    localparam logic [3:0] REG_DEAD_BAND   = 4'd1;
    localparam logic [3:0] REG_STICK_LIMIT = 4'd2;
    localparam logic [3:0] REG_MIN_BYTES   = 4'd3;

    // Register reset values.
    localparam logic [7:0]  IDLE_LIMIT_RST  = 8'd10;
    localparam logic [9:0]  DEAD_BAND_RST   = 10'd10;
    localparam logic [10:0] STICK_LIMIT_RST = 11'd660;
    localparam logic [4:0]  MIN_BYTES_RST   = 5'd17;

    localparam logic [4:0]  BYTE_COUNT_MAX  = 5'd31;
    localparam logic [7:0]  IDLE_COUNT_MAX  = 8'd255;
    localparam logic [15:0] WHEEL_OFFSET    = 16'd1024;

    typedef struct packed {
        logic [7:0]  idle_limit;
        logic [9:0]  dead_band;
        logic [10:0] stick_limit;
        logic [4:0]  min_bytes;
    } cfg_t;

    // Snapshot of the byte window taken when a frame ends.
    typedef struct packed {
        logic [WIN_LEN-1:0][7:0] window;
        logic                    fresh;
    } frame_t;

    typedef struct packed {
        logic signed [10:0] stick_0;
        logic signed [10:0] stick_1;
        logic signed [10:0] stick_2;
        logic signed [10:0] stick_3;
        logic [3:0]         switches;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic signed [15:0] mouse_dz;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
        logic signed [15:0] wheel_value;
        logic [1:0]         frame_status;
    } result_t;

endpackage

/* design/rc_receiver_frame_decoder.sv */
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder
// Remote-control receiver frame decoder: collects serial bytes into an
// 18-byte window and decodes sticks, switches, mouse, keys and wheel when the
// line has been idle long enough.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ------------------------------
//  s_*       in         s_tvalid / s_tready        s_tdata = rx_byte,
//                                                  s_tuser = command
//  m_*       out        m_tvalid / m_tready        m_tdata = decoded fields,
//                                                  m_tuser = frame_status
//  cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One input beat is taken every cycle while the frame queue has room; a byte
// beat only shifts the window, an idle beat that reaches the idle limit pushes
// a snapshot of the window into the queue. The back end decodes one snapshot
// per cycle into the output register while that register is empty or m_tready
// is high; a result passes through the queue and then the output register.
// When m_tready is held low the output register and then the queue
// (QUEUE_DEPTH snapshots) fill, and only then does s_tready drop. Reset
// clears the window, counters, held values and the queue; configuration
// registers return to their defaults. cfg_ready is always high.
//
module rc_receiver_frame_decoder
    import rcfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] rx_byte
    input  logic [0:0]   s_tuser,     // [0] command

    output logic         m_tvalid,
    input  logic         m_tready,
    // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
    // [47:44] switches, [63:48] mouse_dx, [79:64] mouse_dy, [95:80] mouse_dz,
    // [111:96] mouse_buttons, [127:112] key_bits, [143:128] wheel_value
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,     // [1:0] frame_status

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    in_accept;
    logic    push;
    frame_t  push_frame;
    logic    pop;
    logic    q_full;
    logic    q_not_empty;
    frame_t  q_head;
    result_t result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit  <= IDLE_LIMIT_RST;
            cfg_reg.dead_band   <= DEAD_BAND_RST;
            cfg_reg.stick_limit <= STICK_LIMIT_RST;
            cfg_reg.min_bytes   <= MIN_BYTES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IDLE_LIMIT:  cfg_reg.idle_limit  <= cfg_data[7:0];
                REG_DEAD_BAND:   cfg_reg.dead_band   <= cfg_data[9:0];
                REG_STICK_LIMIT: cfg_reg.stick_limit <= cfg_data[10:0];
                REG_MIN_BYTES:   cfg_reg.min_bytes   <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    rcfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_accept  (in_accept),
        .in_command (s_tuser[0]),
        .in_byte    (s_tdata),
        .push       (push),
        .push_frame (push_frame)
    );

    rcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    rcfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_not_empty),
        .head       (q_head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {result.wheel_value, result.key_bits, result.mouse_buttons,
                      result.mouse_dz, result.mouse_dy, result.mouse_dx,
                      result.switches, result.stick_3, result.stick_2,
                      result.stick_1, result.stick_0};
    assign m_tuser = result.frame_status;

endmodule

/* design/rcfd_front.sv */
// ----------------------------------------------------------------------------
// rcfd_front
// Accepts byte and idle beats, keeps the byte window and both counters, and
// pushes a window snapshot into the frame queue when the idle count reaches
// its limit.
// ----------------------------------------------------------------------------
module rcfd_front
    import rcfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_accept,
    input  logic       in_command,
    input  logic [7:0] in_byte,
    output logic       push,
    output frame_t     push_frame
);

    logic [7:0] win_reg [WIN_LEN];
    logic [4:0] byte_count_reg;
    logic [7:0] idle_count_reg;
    logic [7:0] idle_count_next;
    logic       decode_now;

    assign idle_count_next = (idle_count_reg == IDLE_COUNT_MAX) ? idle_count_reg
                                                                : idle_count_reg + 8'd1;
    assign decode_now = in_accept && (in_command == CMD_IDLE)
                        && (idle_count_next >= cfg.idle_limit);

    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            push_frame.window[i] = win_reg[i];
        end
        push_frame.fresh = (byte_count_reg >= cfg.min_bytes);
    end

    assign push = decode_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            byte_count_reg <= 5'd0;
            idle_count_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            if (in_command == CMD_BYTE)
            begin
                for (int i = 0; i < WIN_LEN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_LEN-1] <= in_byte;
                if (byte_count_reg != BYTE_COUNT_MAX)
                begin
                    byte_count_reg <= byte_count_reg + 5'd1;
                end
            end
            else if (decode_now)
            begin
                byte_count_reg <= 5'd0;
                idle_count_reg <= 8'd0;
            end
            else
            begin
                idle_count_reg <= idle_count_next;
            end
        end
    end

endmodule

/* design/rcfd_queue.sv */
// ----------------------------------------------------------------------------
// rcfd_queue
// Small first-in first-out queue of frame snapshots between front and back.
// ----------------------------------------------------------------------------
module rcfd_queue
    import rcfd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output frame_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* design/rcfd_back.sv */
// ----------------------------------------------------------------------------
// rcfd_back
// Decodes the frame at the head of the queue: centers the sticks, applies the
// deadband and limit check, updates the held mouse, key and wheel values and
// loads the result register.
// ----------------------------------------------------------------------------
module rcfd_back
    import rcfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    head_valid,
    input  frame_t  head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic [10:0]        raw [4];
    logic signed [10:0] stick [4];
    logic [3:0]         over;
    logic               ok;
    logic [15:0]        new_dx;
    logic [15:0]        new_dy;
    logic [15:0]        new_dz;
    logic [15:0]        new_buttons;
    logic [15:0]        new_keys;
    logic [15:0]        new_wheel;

    logic [15:0]        dx_reg;
    logic [15:0]        dy_reg;
    logic [15:0]        dz_reg;
    logic [15:0]        buttons_reg;
    logic [15:0]        keys_reg;
    logic [15:0]        wheel_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [WIN_LEN-1:0][7:0] w;
    assign w = head.window;

    // Channels are packed 11 bits each across the first six bytes.
    assign raw[0] = {w[1][2:0], w[0]};
    assign raw[1] = {w[2][5:0], w[1][7:3]};
    assign raw[2] = {w[4][0], w[3], w[2][7:6]};
    assign raw[3] = {w[5][3:0], w[4][7:1]};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic signed [11:0] centered;
            logic [11:0]        mag;
            centered = $signed({~raw[i][10], ~raw[i][10], raw[i][9:0]});
            mag      = centered[11] ? 12'(-centered) : 12'(centered);
            if (mag <= {2'b00, cfg.dead_band})
            begin
                stick[i] = 11'sd0;
                over[i]  = 1'b0;
            end
            else
            begin
                stick[i] = centered[10:0];
                over[i]  = (mag > {1'b0, cfg.stick_limit});
            end
        end
    end

    assign ok          = (over == 4'b0000);
    assign new_dx      = {w[7], w[6]};
    assign new_dy      = {w[9], w[8]};
    assign new_dz      = {w[11], w[10]};
    assign new_buttons = {w[13], w[12]};
    assign new_keys    = {w[15], w[14]};
    assign new_wheel   = {w[17], w[16]} - WHEEL_OFFSET;

    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dx_reg        <= 16'd0;
            dy_reg        <= 16'd0;
            dz_reg        <= 16'd0;
            buttons_reg   <= 16'd0;
            keys_reg      <= 16'd0;
            wheel_reg     <= 16'd0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (ok)
                begin
                    dx_reg      <= new_dx;
                    dy_reg      <= new_dy;
                    dz_reg      <= new_dz;
                    buttons_reg <= new_buttons;
                    keys_reg    <= new_keys;
                    wheel_reg   <= new_wheel;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.stick_0       <= stick[0];
            out_reg.stick_1       <= stick[1];
            out_reg.stick_2       <= stick[2];
            out_reg.stick_3       <= stick[3];
            out_reg.switches      <= w[5][7:4];
            out_reg.mouse_dx      <= ok ? new_dx : dx_reg;
            out_reg.mouse_dy      <= ok ? new_dy : dy_reg;
            out_reg.mouse_dz      <= ok ? new_dz : dz_reg;
            out_reg.mouse_buttons <= ok ? new_buttons : buttons_reg;
            out_reg.key_bits      <= ok ? new_keys : keys_reg;
            out_reg.wheel_value   <= ok ? new_wheel : wheel_reg;
            out_reg.frame_status  <= {head.fresh, ok};
        end
    end

endmodule

/* design/rcfd_checker.sv */
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcfd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // The input side only backs up once the output register is occupied.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    // Leaving reset, no result is on offer.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result offered when leaving reset");

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/sv/rc_receiver_frame_decoder_checker.sv */
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_checker
// Watches the byte, result and register channels of the frame decoder, keeps
// its own copy of the byte window and held values, predicts each decoded
// frame and compares every result beat field by field.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_checker
    import rcfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic [0:0]   s_tuser,

    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [1:0]   m_tuser,

    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [15:0]  cfg_data,

    output int           mismatches,
    output int           frames_owed,
    output int           frames_decoded,
    output int           frames_rejected
);

    logic [7:0]  window [WIN_LEN];
    logic [4:0]  byte_cnt;
    logic [7:0]  idle_cnt;
    logic [15:0] held_dx;
    logic [15:0] held_dy;
    logic [15:0] held_dz;
    logic [15:0] held_buttons;
    logic [15:0] held_keys;
    logic [15:0] held_wheel;
    cfg_t        regs;
    result_t     owed_q [$];

    initial
    begin
        mismatches      = 0;
        frames_owed     = 0;
        frames_decoded  = 0;
        frames_rejected = 0;
    end

    task automatic flag(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic signed [10:0] center_stick(input logic [10:0] raw);
        int v;
        int mag;
        v   = int'(raw) - 1024;
        mag = (v < 0) ? -v : v;
        if (mag <= int'(regs.dead_band))
            v = 0;
        return v[10:0];
    endfunction

    function automatic int magnitude(input logic signed [10:0] s);
        int v;
        v = s;
        return (v < 0) ? -v : v;
    endfunction

    // Decodes the current window into one result and clears both counters.
    task automatic decode_window();
        logic [47:0] head;
        result_t     r;
        logic        ok;
        for (int i = 0; i < 6; i++)
            head[8*i +: 8] = window[i];
        r.stick_0  = center_stick(head[10:0]);
        r.stick_1  = center_stick(head[21:11]);
        r.stick_2  = center_stick(head[32:22]);
        r.stick_3  = center_stick(head[43:33]);
        r.switches = head[47:44];
        ok = magnitude(r.stick_0) <= int'(regs.stick_limit) &&
             magnitude(r.stick_1) <= int'(regs.stick_limit) &&
             magnitude(r.stick_2) <= int'(regs.stick_limit) &&
             magnitude(r.stick_3) <= int'(regs.stick_limit);
        if (ok)
        begin
            held_dx      = {window[7], window[6]};
            held_dy      = {window[9], window[8]};
            held_dz      = {window[11], window[10]};
            held_buttons = {window[13], window[12]};
            held_keys    = {window[15], window[14]};
            held_wheel   = {window[17], window[16]} - WHEEL_OFFSET;
        end
        else
        begin
            frames_rejected++;
        end
        r.mouse_dx      = held_dx;
        r.mouse_dy      = held_dy;
        r.mouse_dz      = held_dz;
        r.mouse_buttons = held_buttons;
        r.key_bits      = held_keys;
        r.wheel_value   = held_wheel;
        r.frame_status  = {byte_cnt >= regs.min_bytes, ok};
        owed_q.push_back(r);
        frames_decoded++;
        byte_cnt = '0;
        idle_cnt = '0;
    endtask

    task automatic apply_beat(input logic cmd, input logic [7:0] data);
        if (cmd == CMD_BYTE)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                window[i] = window[i + 1];
            window[WIN_LEN - 1] = data;
            if (byte_cnt != BYTE_COUNT_MAX)
                byte_cnt++;
        end
        else
        begin
            if (idle_cnt != IDLE_COUNT_MAX)
                idle_cnt++;
            if (idle_cnt >= regs.idle_limit)
                decode_window();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    task automatic check_result();
        result_t want;
        if (owed_q.size() == 0)
        begin
            flag($sformatf("result beat with no frame pending, tdata %h", m_tdata));
            return;
        end
        want = owed_q.pop_front();
        check_field("stick_0",       m_tdata[10:0],    {want.stick_0});
        check_field("stick_1",       m_tdata[21:11],   {want.stick_1});
        check_field("stick_2",       m_tdata[32:22],   {want.stick_2});
        check_field("stick_3",       m_tdata[43:33],   {want.stick_3});
        check_field("switches",      m_tdata[47:44],   want.switches);
        check_field("mouse_dx",      m_tdata[63:48],   want.mouse_dx);
        check_field("mouse_dy",      m_tdata[79:64],   want.mouse_dy);
        check_field("mouse_dz",      m_tdata[95:80],   want.mouse_dz);
        check_field("mouse_buttons", m_tdata[111:96],  want.mouse_buttons);
        check_field("key_bits",      m_tdata[127:112], want.key_bits);
        check_field("wheel_value",   m_tdata[143:128], want.wheel_value);
        check_field("frame_status",  m_tuser,          want.frame_status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
                window[i] = '0;
            byte_cnt         = '0;
            idle_cnt         = '0;
            held_dx          = '0;
            held_dy          = '0;
            held_dz          = '0;
            held_buttons     = '0;
            held_keys        = '0;
            held_wheel       = '0;
            regs.idle_limit  = IDLE_LIMIT_RST;
            regs.dead_band   = DEAD_BAND_RST;
            regs.stick_limit = STICK_LIMIT_RST;
            regs.min_bytes   = MIN_BYTES_RST;
            owed_q.delete();
            frames_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IDLE_LIMIT:  regs.idle_limit  = cfg_data[7:0];
                    REG_DEAD_BAND:   regs.dead_band   = cfg_data[9:0];
                    REG_STICK_LIMIT: regs.stick_limit = cfg_data[10:0];
                    REG_MIN_BYTES:   regs.min_bytes   = cfg_data[4:0];
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            frames_owed <= owed_q.size();
        end
    end

endmodule

/* tb/sv/rc_receiver_frame_decoder_test.sv */
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_test
// Drives byte and idle-tick beats into the frame decoder under a series of
// register settings, with random gaps on the input and random stalls on the
// output, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_test;

    import rcfd_pkg::*;

    // Stimulus stops once this many input beats have gone in.
    localparam int ITEM_TARGET   = 1600;
    // Beats per random phase; the phase with the longest idle limit gets more.
    localparam int PHASE_ITEMS   = 160;
    // Cycles to let pass once nothing is owed: the result path is the snapshot
    // queue and the output register, so this covers anything still in flight.
    localparam int SETTLE_CYCLES = 8;
    // Far above the slowest legal run.
    localparam int CYCLE_LIMIT   = 500000;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [7:0]   s_tdata   = '0;
    logic [0:0]   s_tuser   = CMD_BYTE;
    logic         m_tready  = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [3:0]   cfg_index = REG_IDLE_LIMIT;
    logic [15:0]  cfg_data  = '0;

    logic         s_tready;
    logic         m_tvalid;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_ready;

    int           mismatches;
    int           frames_owed;
    int           frames_decoded;
    int           frames_rejected;

    // While steady is set neither side idles, which gives one long stretch
    // of back-to-back beats on both channels.
    bit           steady         = 1'b0;
    int           beats_sent     = 0;
    int           settings_used  = 0;
    int           cycle_count    = 0;

    // The register values last written; they shape the stick values and the
    // number of idle ticks so that most frames land near the interesting
    // boundaries of the current setting.
    logic [7:0]   cur_idle  = IDLE_LIMIT_RST;
    logic [9:0]   cur_band  = DEAD_BAND_RST;
    logic [10:0]  cur_limit = STICK_LIMIT_RST;

    rc_receiver_frame_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rc_receiver_frame_decoder_checker frame_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .frames_owed     (frames_owed),
        .frames_decoded  (frames_decoded),
        .frames_rejected (frames_rejected)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The result side stalls in roughly 15 percent of cycles, except during
    // the steady stretch.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 15);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d frames still owed",
                     cycle_count, frames_owed);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sends one beat. Random gaps go in front of it; tvalid stays high from
    // one beat to the next when there is no gap, so it is never lowered and
    // raised within the same time step.
    task automatic send_beat(input logic cmd, input logic [7:0] data);
        while (!steady && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // Holds the input off until every predicted frame has come out, then
    // lets the decoder settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (frames_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register beat; cfg_valid is left high for the caller to lower.
    task automatic write_reg(input logic [3:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Registers are only written with the decoder drained, so a setting never
    // changes under a frame that is still in the result path.
    task automatic set_config(input logic [7:0] idle, input logic [9:0] band,
                              input logic [10:0] limit, input logic [4:0] min_count);
        wait_drained();
        write_reg(REG_IDLE_LIMIT,  16'(idle));
        write_reg(REG_DEAD_BAND,   16'(band));
        write_reg(REG_STICK_LIMIT, 16'(limit));
        write_reg(REG_MIN_BYTES,   16'(min_count));
        cfg_valid <= 1'b0;
        cur_idle  = idle;
        cur_band  = band;
        cur_limit = limit;
        settings_used++;
    endtask

    // Picks a raw 11-bit stick value: mostly within the stick limit around
    // center, often right at the deadband or limit edge, sometimes at the
    // ends of the range or right at center, or anywhere at all.
    function automatic logic [10:0] pick_stick();
        int v;
        int off;
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            off = $urandom_range(0, (cur_limit > 1023) ? 1023 : cur_limit);
        else if (sel < 7)
            off = cur_band + $urandom_range(1);
        else if (sel == 7)
            off = cur_limit + $urandom_range(1);
        else
            off = 0;
        v = ($urandom_range(1) == 1) ? 1024 + off : 1024 - off;
        if (sel == 8)
        begin
            case ($urandom_range(3))
                0:       v = 0;
                1:       v = 2047;
                2:       v = 1023;
                default: v = 1024;
            endcase
        end
        else if (sel == 9)
        begin
            v = $urandom_range(2047);
        end
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return v[10:0];
    endfunction

    // A full window: sticks and switches packed into the first six bytes,
    // random mouse, button, key and wheel bytes after them.
    function automatic logic [WIN_LEN-1:0][7:0] random_frame();
        logic [WIN_LEN-1:0][7:0] f;
        logic [47:0]             head;
        logic [3:0]              sw;
        sw   = 4'($urandom_range(15));
        head = {sw, pick_stick(), pick_stick(), pick_stick(), pick_stick()};
        for (int i = 0; i < WIN_LEN; i++)
            f[i] = 8'($urandom_range(255));
        for (int i = 0; i < 6; i++)
            f[i] = head[8*i +: 8];
        return f;
    endfunction

    // Sends the last nbytes of the frame (or random filler ahead of it when
    // nbytes is longer than the window), then nidle idle ticks. Now and then
    // a stray idle tick falls between the bytes, which must not reset the
    // idle count.
    task automatic send_frame(input logic [WIN_LEN-1:0][7:0] frame,
                              input int nbytes, input int nidle);
        int idx;
        for (int i = 0; i < nbytes; i++)
        begin
            idx = i + WIN_LEN - nbytes;
            if (cur_idle > 1 && $urandom_range(29) == 0)
                send_beat(CMD_IDLE, 8'($urandom_range(255)));
            if (idx < 0)
                send_beat(CMD_BYTE, 8'($urandom_range(255)));
            else
                send_beat(CMD_BYTE, frame[idx]);
        end
        repeat (nidle) send_beat(CMD_IDLE, 8'($urandom_range(255)));
    endtask

    // One setting, then frames until the phase has used its beats. Most
    // frames are a proper 18 bytes closed by exactly the idle limit; the rest
    // are short, overlong (the byte count saturates), cut off early, or
    // followed by extra idle ticks.
    task automatic run_phase(input logic [7:0] idle, input logic [9:0] band,
                             input logic [10:0] limit, input logic [4:0] min_count,
                             input int budget);
        int start;
        int nbytes;
        int nidle;
        int sel;
        set_config(idle, band, limit, min_count);
        start = beats_sent;
        while (beats_sent - start < budget)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
                nbytes = WIN_LEN;
            else if (sel == 7)
                nbytes = WIN_LEN - 1;
            else if (sel == 8)
                nbytes = $urandom_range(0, 16);
            else
                nbytes = $urandom_range(19, 40);
            sel = $urandom_range(9);
            if (cur_idle == 0)
                nidle = $urandom_range(1, 3);
            else if (sel < 8)
                nidle = cur_idle;
            else if (sel == 8)
                nidle = $urandom_range(1, cur_idle);
            else
                nidle = cur_idle + $urandom_range(1, 3);
            send_frame(random_frame(), nbytes, nidle);
            // Occasionally the sender waits for the result side to catch up.
            if ($urandom_range(49) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [WIN_LEN-1:0][7:0] first_frame;
        logic [47:0]             first_head;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with an idle limit of one so each idle tick decodes.
        // The first tick decodes the all-zero window left by reset: every
        // stick sits at full negative scale, so the frame fails and is stale.
        set_config(8'd1, DEAD_BAND_RST, STICK_LIMIT_RST, MIN_BYTES_RST);
        send_beat(CMD_IDLE, 8'h00);

        // Then a fresh frame with two sticks exactly at the limit, one exactly
        // at the deadband and one just past it, all switch bits set, mouse dx
        // and dy at their extremes, dz at minus one, a wheel raw value one
        // below the offset so the wheel wraps to minus one. The two extra idle
        // ticks decode the same window again with no bytes counted.
        first_head  = {4'hF, 11'(1024 - 11), 11'(1024 + 10),
                       11'(1024 - 660), 11'(1024 + 660)};
        first_frame = {8'h03, 8'hFF, 8'h00, 8'h00, 8'h55, 8'hAA,
                       8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, first_head};
        send_frame(first_frame, WIN_LEN, 3);

        // Reset values with both sides running flat out.
        steady = 1'b1;
        run_phase(IDLE_LIMIT_RST, DEAD_BAND_RST, STICK_LIMIT_RST, MIN_BYTES_RST, 300);
        steady = 1'b0;

        // Low extremes: every idle tick decodes, no deadband, any off-center
        // stick fails, and every frame counts as fresh.
        run_phase(8'd0, 10'd0, 11'd0, 5'd0, PHASE_ITEMS);

        // High extremes: the longest idle limit, the widest deadband, a stick
        // limit no frame can exceed, and a byte count only saturation reaches.
        run_phase(8'd255, 10'd1023, 11'd2047, 5'd31, 500);

        // Stick limit at exactly full scale.
        run_phase(8'd1, 10'd1023, 11'd1024, 5'd18, PHASE_ITEMS);

        while (beats_sent < ITEM_TARGET)
            run_phase(8'($urandom_range(1, 24)), 10'($urandom_range(1023)),
                      11'($urandom_range(2047)), 5'($urandom_range(31)), PHASE_ITEMS);

        wait_drained();

        $display("Covered %0d input beats under %0d register settings.",
                 beats_sent, settings_used);
        $display("Decoded %0d frames, %0d of them rejected for stick range.",
                 frames_decoded, frames_rejected);
        if (mismatches == 0 && frames_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
